// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent assertions used in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/csn_pkg.sv =====
// ---------------------------------------------------------------------------
// csn_pkg
// Shared widths, codes and control types of the column statistics block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package csn_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 12;
    localparam int COUNT_W     = 17;
    localparam int SUM_W       = 40;
    localparam int SQ_W        = 63;
    localparam int WIDE_W      = 80;
    localparam int DVS_W       = 33;
    localparam int MUL_W       = 32;
    localparam int NUM_W       = SAMPLE_BITS + 1 + FRAC_BITS;
    localparam int STD_W       = 23;
    localparam int TOL_W       = 13;
    localparam int CAT_W       = 4;
    localparam int TYPE_W      = 2;
    localparam int CFG_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_BITS    = SAMPLE_BITS * 4 + TYPE_W + STD_W + COUNT_W;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int IN_DATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;

    // parameter defaults
    localparam int MAX_SAMPLES_DEF    = 65536;
    localparam int DISTINCT_SLOTS_DEF = 10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LIMIT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOLERANCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CATEGORICAL_LIMIT = 2'd3;

    // register reset values
    localparam logic [COUNT_W-1:0] SAMPLE_LIMIT_RST = 17'd1000;
    localparam logic [TOL_W-1:0]   MATCH_TOL_RST    = 13'd4;
    localparam logic [TOL_W-1:0]   MIN_RANGE_RST    = 13'd4;
    localparam logic [CAT_W-1:0]   CAT_LIMIT_RST    = 4'd5;

    typedef enum logic [TYPE_W-1:0] {
        COL_NUMERIC     = 2'd0,
        COL_CATEGORICAL = 2'd1,
        COL_BINARY      = 2'd2
    } col_type_t;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ACC_MUL,
        OP_ACC_UPD,
        OP_T0,
        OP_T1,
        OP_S0,
        OP_S1,
        OP_S2,
        OP_NN,
        OP_VLOAD,
        OP_DIV,
        OP_MLOAD,
        OP_RUN,
        OP_EMIT_ST,
        OP_XF_LOAD,
        OP_EMIT_XF
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic out_free;
        logic xf_use_div;
        logic last;
    } dp_status_t;

endpackage

// ===== sv/csn_ctrl.sv =====
// ---------------------------------------------------------------------------
// csn_ctrl
// Sequencer for accumulate, statistics and transform operations.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module csn_ctrl
    import csn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_cmd,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [16:0] {
        S_IDLE    = 17'b00000000000000001,
        S_ACC_MUL = 17'b00000000000000010,
        S_ACC_UPD = 17'b00000000000000100,
        S_T0      = 17'b00000000000001000,
        S_T1      = 17'b00000000000010000,
        S_S0      = 17'b00000000000100000,
        S_S1      = 17'b00000000001000000,
        S_S2      = 17'b00000000010000000,
        S_NN      = 17'b00000000100000000,
        S_VLOAD   = 17'b00000001000000000,
        S_VDIV    = 17'b00000010000000000,
        S_MLOAD   = 17'b00000100000000000,
        S_RUN     = 17'b00001000000000000,
        S_EMIT    = 17'b00010000000000000,
        S_XF_LOAD = 17'b00100000000000000,
        S_XF_DIV  = 17'b01000000000000000,
        S_XF_EMIT = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = in_cmd ? S_XF_LOAD : S_ACC_MUL;
                end
            end
            S_ACC_MUL:
            begin
                cmd.op     = OP_ACC_MUL;
                state_next = S_ACC_UPD;
            end
            S_ACC_UPD:
            begin
                cmd.op     = OP_ACC_UPD;
                state_next = status.last ? S_T0 : S_IDLE;
            end
            S_T0:
            begin
                cmd.op     = OP_T0;
                state_next = S_T1;
            end
            S_T1:
            begin
                cmd.op     = OP_T1;
                state_next = S_S0;
            end
            S_S0:
            begin
                cmd.op     = OP_S0;
                state_next = S_S1;
            end
            S_S1:
            begin
                cmd.op     = OP_S1;
                state_next = S_S2;
            end
            S_S2:
            begin
                cmd.op     = OP_S2;
                state_next = S_NN;
            end
            S_NN:
            begin
                cmd.op     = OP_NN;
                state_next = S_VLOAD;
            end
            S_VLOAD:
            begin
                cmd.op     = OP_VLOAD;
                state_next = S_VDIV;
            end
            S_VDIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_MLOAD;
                end
                else
                begin
                    cmd.op = OP_DIV;
                end
            end
            S_MLOAD:
            begin
                cmd.op     = OP_MLOAD;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (status.div_done && status.sqrt_done)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.op = OP_RUN;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_EMIT_ST;
                    state_next = S_IDLE;
                end
            end
            S_XF_LOAD:
            begin
                cmd.op     = OP_XF_LOAD;
                state_next = status.xf_use_div ? S_XF_DIV : S_XF_EMIT;
            end
            S_XF_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_XF_EMIT;
                end
                else
                begin
                    cmd.op = OP_DIV;
                end
            end
            S_XF_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_EMIT_XF;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/csn_dp.sv =====
// ---------------------------------------------------------------------------
// csn_dp
// Accumulators, shared multiplier, serial divider, serial square root,
// configuration registers and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module csn_dp
    import csn_pkg::*;
#(
    parameter int MAX_SAMPLES    = MAX_SAMPLES_DEF,
    parameter int DISTINCT_SLOTS = DISTINCT_SLOTS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                         in_last,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_wdata,
    input  dp_cmd_t                      cmd,
    output dp_status_t                   status,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic                         out_kind,
    output logic [OUT_DATA_W-1:0]        out_data
);

    localparam int DCW = $clog2(DISTINCT_SLOTS + 1);
    localparam int IW  = $clog2(DISTINCT_SLOTS);
    localparam logic signed [SAMPLE_BITS-1:0] ONE_Q = SAMPLE_BITS'(1 << FRAC_BITS);
    localparam logic signed [NUM_W+1:0] SAT_HI = (NUM_W+2)'((1 << (SAMPLE_BITS-1)) - 1);
    localparam logic signed [NUM_W+1:0] SAT_LO = -(NUM_W+2)'(1 << (SAMPLE_BITS-1));
    localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;
    localparam logic [STD_W-1:0] STD_MAX = {STD_W{1'b1}};

    // configuration
    logic [COUNT_W-1:0] limit_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [TOL_W-1:0]   min_range_reg;
    logic [CAT_W-1:0]   cat_reg;

    // accumulators
    logic [COUNT_W-1:0]            cnt_reg;
    logic signed [SAMPLE_BITS-1:0] min_reg, max_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic [SQ_W-1:0]               sumsq_reg;
    logic [COUNT_W-1:0]            hits_reg;
    logic [DCW-1:0]                dcnt_reg;
    logic signed [SAMPLE_BITS-1:0] slot_reg [DISTINCT_SLOTS];

    // latched statistics
    col_type_t                     ltype_reg;
    logic signed [SAMPLE_BITS-1:0] lmin_reg, lmax_reg;

    // working registers
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          last_reg;
    logic [2*MUL_W-1:0]            prod_reg;
    logic [WIDE_W-1:0]             t_reg, s_reg;
    logic [WIDE_W-1:0]             dd_reg;
    logic [DVS_W-1:0]              rem_reg, dvs_reg;
    logic [6:0]                    div_cnt_reg;
    logic                          xneg_reg;
    logic [63:0]                   sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [5:0]                    sq_cnt_reg;
    logic                          out_valid_reg, out_kind_reg;
    logic [OUT_DATA_W-1:0]         out_data_reg;

    // ---------------------------------------------------------------------
    // shared multiplier operands
    logic [SAMPLE_BITS-1:0] absx;
    logic [SUM_W-1:0]       absum;
    logic [MUL_W-1:0]       mul_a, mul_b;

    assign absx  = x_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x_reg) : SAMPLE_BITS'(x_reg);
    assign absum = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_ACC_MUL:
            begin
                mul_a = MUL_W'(absx);
                mul_b = MUL_W'(absx);
            end
            OP_T0:
            begin
                mul_a = MUL_W'(cnt_reg);
                mul_b = sumsq_reg[MUL_W-1:0];
            end
            OP_T1:
            begin
                mul_a = MUL_W'(cnt_reg);
                mul_b = MUL_W'(sumsq_reg[SQ_W-1:MUL_W]);
            end
            OP_S0:
            begin
                mul_a = absum[MUL_W-1:0];
                mul_b = absum[MUL_W-1:0];
            end
            OP_S1:
            begin
                mul_a = absum[MUL_W-1:0];
                mul_b = MUL_W'(absum[SUM_W-1:MUL_W]);
            end
            OP_S2:
            begin
                mul_a = MUL_W'(absum[SUM_W-1:MUL_W]);
                mul_b = MUL_W'(absum[SUM_W-1:MUL_W]);
            end
            OP_NN:
            begin
                mul_a = MUL_W'(cnt_reg);
                mul_b = MUL_W'(cnt_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // distinct value search, all slots in parallel
    logic [DISTINCT_SLOTS-1:0] slot_hit;
    logic                      found;

    always_comb
    begin
        logic signed [SAMPLE_BITS:0] d;
        logic [SAMPLE_BITS:0]        ad;
        for (int i = 0; i < DISTINCT_SLOTS; i++)
        begin
            d  = {slot_reg[i][SAMPLE_BITS-1], slot_reg[i]} - {x_reg[SAMPLE_BITS-1], x_reg};
            ad = d[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-d) : (SAMPLE_BITS+1)'(d);
            slot_hit[i] = (DCW'(i) < dcnt_reg) && (ad < (SAMPLE_BITS+1)'(tol_reg));
        end
    end

    assign found = |slot_hit;

    logic acc_en, det_en, is_bin, slot_wr;

    assign acc_en  = (cmd.op == OP_ACC_UPD) && (cnt_reg < COUNT_W'(MAX_SAMPLES));
    assign det_en  = cnt_reg < limit_reg;
    assign is_bin  = (x_reg == '0) || (x_reg == ONE_Q);
    assign slot_wr = acc_en && det_en && !found && (dcnt_reg < DCW'(DISTINCT_SLOTS));

    // ---------------------------------------------------------------------
    // divider step: one quotient bit per cycle
    logic [DVS_W:0]   trial;
    logic             trial_ge;
    logic [DVS_W-1:0] rem_step;
    logic             div_busy;

    assign trial    = {rem_reg, dd_reg[WIDE_W-1]};
    assign trial_ge = trial >= {1'b0, dvs_reg};
    assign rem_step = trial_ge ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
    assign div_busy = div_cnt_reg != '0;

    // square root step: two radicand bits per cycle
    logic [63:0] sq_rb;
    logic        sq_ge;
    logic        sq_busy;

    assign sq_rb   = sq_r_reg + sq_bit_reg;
    assign sq_ge   = sq_v_reg >= sq_rb;
    assign sq_busy = sq_cnt_reg != '0;

    // ---------------------------------------------------------------------
    // statistics result
    logic                   sum_neg;
    logic [SUM_W-1:0]       mean_mag;
    logic [SAMPLE_BITS-1:0] mean_q;
    logic [STD_W-1:0]       sd_val;
    logic [COUNT_W-1:0]     det_n;
    col_type_t              type_val;

    assign sum_neg  = sum_reg[SUM_W-1];
    assign mean_mag = dd_reg[SUM_W-1:0] + SUM_W'(sum_neg && (rem_reg != '0));
    assign mean_q   = sum_neg ? SAMPLE_BITS'(-mean_mag) : SAMPLE_BITS'(mean_mag);
    assign sd_val   = (sq_r_reg > 64'(STD_MAX)) ? STD_MAX : sq_r_reg[STD_W-1:0];
    assign det_n    = (cnt_reg < limit_reg) ? cnt_reg : limit_reg;

    always_comb
    begin
        if ((hits_reg == det_n) && (dcnt_reg <= DCW'(2)))
        begin
            type_val = COL_BINARY;
        end
        else if (8'(dcnt_reg) <= 8'(cat_reg))
        begin
            type_val = COL_CATEGORICAL;
        end
        else
        begin
            type_val = COL_NUMERIC;
        end
    end

    // ---------------------------------------------------------------------
    // transform
    logic signed [SAMPLE_BITS:0]   range;
    logic signed [SAMPLE_BITS:0]   xdiff;
    logic signed [NUM_W-1:0]       num;
    logic [NUM_W-1:0]              absnum;
    logic                          use_div;
    logic [NUM_W:0]                q_mag;
    logic signed [NUM_W+1:0]       q_signed;
    logic signed [SAMPLE_BITS-1:0] y_div, y_val;
    logic signed [SAMPLE_BITS+1:0] two_x, mid_sum;

    assign range   = {lmax_reg[SAMPLE_BITS-1], lmax_reg} - {lmin_reg[SAMPLE_BITS-1], lmin_reg};
    assign xdiff   = {x_reg[SAMPLE_BITS-1], x_reg} - {lmin_reg[SAMPLE_BITS-1], lmin_reg};
    assign num     = {xdiff, {FRAC_BITS{1'b0}}};
    assign absnum  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign use_div = (ltype_reg == COL_NUMERIC) && (range > 0)
                     && (range >= $signed((SAMPLE_BITS+1)'(min_range_reg)));

    assign q_mag    = {1'b0, dd_reg[NUM_W-1:0]} + (NUM_W+1)'(xneg_reg && (rem_reg != '0));
    assign q_signed = xneg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

    always_comb
    begin
        if (q_signed > SAT_HI)
        begin
            y_div = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (q_signed < SAT_LO)
        begin
            y_div = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            y_div = q_signed[SAMPLE_BITS-1:0];
        end
    end

    assign two_x   = {x_reg[SAMPLE_BITS-1], x_reg, 1'b0};
    assign mid_sum = {{2{lmin_reg[SAMPLE_BITS-1]}}, lmin_reg}
                     + {{2{lmax_reg[SAMPLE_BITS-1]}}, lmax_reg};

    always_comb
    begin
        case (ltype_reg)
            COL_NUMERIC:     y_val = use_div ? y_div : x_reg;
            COL_CATEGORICAL: y_val = (two_x > mid_sum) ? ONE_Q : '0;
            default:         y_val = x_reg;
        endcase
    end

    // output words, fields from bit 0 up
    logic [OUT_DATA_W-1:0] st_word, xf_word;

    assign st_word = OUT_DATA_W'({cnt_reg, sd_val, mean_q, max_reg, min_reg,
                                  type_val, {SAMPLE_BITS{1'b0}}});
    assign xf_word = OUT_DATA_W'({lmax_reg, lmin_reg, ltype_reg, y_val});

    // ---------------------------------------------------------------------
    // control and accumulator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= SAMPLE_LIMIT_RST;
            tol_reg       <= MATCH_TOL_RST;
            min_range_reg <= MIN_RANGE_RST;
            cat_reg       <= CAT_LIMIT_RST;
            cnt_reg       <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            sum_reg       <= '0;
            sumsq_reg     <= '0;
            hits_reg      <= '0;
            dcnt_reg      <= '0;
            ltype_reg     <= COL_NUMERIC;
            lmin_reg      <= '0;
            lmax_reg      <= '0;
            div_cnt_reg   <= '0;
            sq_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_SAMPLE_LIMIT:      limit_reg     <= cfg_wdata;
                    REG_MATCH_TOLERANCE:   tol_reg       <= cfg_wdata[TOL_W-1:0];
                    REG_MIN_RANGE:         min_range_reg <= cfg_wdata[TOL_W-1:0];
                    REG_CATEGORICAL_LIMIT: cat_reg       <= cfg_wdata[CAT_W-1:0];
                    default:               cat_reg       <= cat_reg;
                endcase
            end

            // accumulate one sample
            if (acc_en)
            begin
                if ((cnt_reg == '0) || (x_reg < min_reg))
                begin
                    min_reg <= x_reg;
                end
                if ((cnt_reg == '0) || (x_reg > max_reg))
                begin
                    max_reg <= x_reg;
                end
                sum_reg   <= sum_reg + SUM_W'(x_reg);
                sumsq_reg <= sumsq_reg + SQ_W'(prod_reg[2*SAMPLE_BITS-1:0]);
                cnt_reg   <= cnt_reg + 1'b1;
                if (det_en && is_bin)
                begin
                    hits_reg <= hits_reg + 1'b1;
                end
                if (slot_wr)
                begin
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
            end

            // divider and square root counters
            if (cmd.op == OP_VLOAD)
            begin
                div_cnt_reg <= 7'(WIDE_W);
            end
            else if (cmd.op == OP_MLOAD)
            begin
                div_cnt_reg <= 7'(SUM_W);
                sq_cnt_reg  <= 6'd32;
            end
            else if ((cmd.op == OP_XF_LOAD) && use_div)
            begin
                div_cnt_reg <= 7'(NUM_W);
            end
            else if ((cmd.op == OP_DIV) || (cmd.op == OP_RUN))
            begin
                if (div_busy)
                begin
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                end
                if (sq_busy && (cmd.op == OP_RUN))
                begin
                    sq_cnt_reg <= sq_cnt_reg - 1'b1;
                end
            end

            // statistics out: latch and clear
            if (cmd.op == OP_EMIT_ST)
            begin
                ltype_reg <= type_val;
                lmin_reg  <= min_reg;
                lmax_reg  <= max_reg;
                cnt_reg   <= '0;
                min_reg   <= '0;
                max_reg   <= '0;
                sum_reg   <= '0;
                sumsq_reg <= '0;
                hits_reg  <= '0;
                dcnt_reg  <= '0;
            end

            // output valid
            if ((cmd.op == OP_EMIT_ST) || (cmd.op == OP_EMIT_XF))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            x_reg    <= in_sample;
            last_reg <= in_last;
        end

        if (slot_wr)
        begin
            slot_reg[dcnt_reg[IW-1:0]] <= x_reg;
        end

        // multiplier and wide sums
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_T1:
            begin
                t_reg <= WIDE_W'(prod_reg);
            end
            OP_S0:
            begin
                t_reg <= t_reg + (WIDE_W'(prod_reg) << MUL_W);
            end
            OP_S1:
            begin
                s_reg <= WIDE_W'(prod_reg);
            end
            OP_S2:
            begin
                s_reg <= s_reg + (WIDE_W'(prod_reg) << (MUL_W + 1));
            end
            OP_NN:
            begin
                s_reg <= s_reg + (WIDE_W'(prod_reg) << (2 * MUL_W));
            end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase

        // divider
        if (cmd.op == OP_VLOAD)
        begin
            dvs_reg <= prod_reg[DVS_W-1:0];
            dd_reg  <= (t_reg >= s_reg) ? (t_reg - s_reg) : '0;
            rem_reg <= '0;
        end
        else if (cmd.op == OP_MLOAD)
        begin
            dvs_reg <= DVS_W'(cnt_reg);
            dd_reg  <= {absum, {(WIDE_W-SUM_W){1'b0}}};
            rem_reg <= '0;
        end
        else if (cmd.op == OP_XF_LOAD)
        begin
            dvs_reg  <= DVS_W'(range[SAMPLE_BITS-1:0]);
            dd_reg   <= {absnum, {(WIDE_W-NUM_W){1'b0}}};
            rem_reg  <= '0;
            xneg_reg <= num[NUM_W-1];
        end
        else if (((cmd.op == OP_DIV) || (cmd.op == OP_RUN)) && div_busy)
        begin
            rem_reg <= rem_step;
            dd_reg  <= {dd_reg[WIDE_W-2:0], trial_ge};
        end

        // square root
        if (cmd.op == OP_MLOAD)
        begin
            sq_v_reg   <= dd_reg[63:0];
            sq_r_reg   <= '0;
            sq_bit_reg <= SQRT_BIT0;
        end
        else if ((cmd.op == OP_RUN) && sq_busy)
        begin
            if (sq_ge)
            begin
                sq_v_reg <= sq_v_reg - sq_rb;
                sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_r_reg <= sq_r_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end

        // output word
        if (cmd.op == OP_EMIT_ST)
        begin
            out_kind_reg <= 1'b0;
            out_data_reg <= st_word;
        end
        else if (cmd.op == OP_EMIT_XF)
        begin
            out_kind_reg <= 1'b1;
            out_data_reg <= xf_word;
        end
    end

    // status to the controller
    assign status.div_done   = !div_busy;
    assign status.sqrt_done  = !sq_busy;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.xf_use_div = use_div;
    assign status.last       = last_reg;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/column_stats_normalizer.sv =====
// ---------------------------------------------------------------------------
// column_stats_normalizer
// Two-pass statistics and min-max scaling of one Q12.12 data column.
// Input stream: tuser is the command (0 accumulate, 1 transform), tdata the
// sample, tlast marks the final sample of the accumulate pass. The block
// takes one word at a time; tready is high only while it is idle.
// Output stream: one word per transform sample, and one statistics word on
// the accumulate sample marked last. tuser tells the two apart.
// Accumulate word with tlast: the output word waits on the 80-step variance
// division, then on the 40-step mean division running beside the 32-step
// square root. Scaled numeric transform words wait on the 37-step serial
// divider; categorical and pass-through columns skip it.
// A one-word output register sits between the sides; the block stalls only
// when a new result finds that register still full.
// Configuration is written through cfg_wr_en / cfg_index / cfg_wdata; the
// user must write it only while the block is idle, which the block itself
// does not enforce. Reset restores register defaults, clears accumulators
// and latched statistics and drops the output word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module column_stats_normalizer
    import csn_pkg::*;
#(
    parameter int MAX_SAMPLES    = MAX_SAMPLES_DEF,
    parameter int DISTINCT_SLOTS = DISTINCT_SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // sample
    input  logic                  s_axis_tuser,   // cmd
    input  logic                  s_axis_tlast,   // last
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // transformed, column_type,
                                                  // min_value, max_value,
                                                  // mean_value, std_dev,
                                                  // sample_total, zero pad
    output logic                  m_axis_tuser,   // kind
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // controller
    csn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    csn_dp #(
        .MAX_SAMPLES    (MAX_SAMPLES),
        .DISTINCT_SLOTS (DISTINCT_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .in_last   (s_axis_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_kind  (m_axis_tuser),
        .out_data  (m_axis_tdata)
    );

    // checks
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `ASSERT_IMPLIES(a_xf_word_clean, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[137:74] == '0)
    `ASSERT_IMPLIES(a_stats_word, clk, rst_n, m_axis_tvalid && !m_axis_tuser, (m_axis_tdata[23:0] == '0) && (m_axis_tdata[137:121] != '0))

endmodule
